@@ rtl/resp_array_command_parser_defines.svh @@
// ----------------------------------------------------------------------------
// resp array command parser assertion macros
// shared assertion forms, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef RESP_ARRAY_COMMAND_PARSER_DEFINES_SVH
`define RESP_ARRAY_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication
`define RAPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rapc_pkg.sv @@
// ----------------------------------------------------------------------------
// rapc_pkg
// types and constants of the resp array command parser
// ----------------------------------------------------------------------------
package rapc_pkg;

  localparam int BYTE_W    = 8;
  localparam int NUM_W     = 31;
  localparam int ACC_W     = 32;
  localparam int KIND_W    = 3;
  localparam int TRAIL_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_DEPTH = 4;

  localparam logic [NUM_W-1:0] MAX_DEFAULT = 31'h7FFF_FFFF;

  localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARG_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK_LENGTH = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_COMPLETE = 3'd2,
    KIND_ERROR    = 3'd3,
    KIND_INCOMPL  = 3'd4
  } kind_t;

  typedef enum logic [8:0] {
    PH_STAR     = 9'b000000001,
    PH_COUNT    = 9'b000000010,
    PH_COUNT_CR = 9'b000000100,
    PH_DOLLAR   = 9'b000001000,
    PH_LEN      = 9'b000010000,
    PH_LEN_CR   = 9'b000100000,
    PH_PAYLOAD  = 9'b001000000,
    PH_TRAILER  = 9'b010000000,
    PH_DRAIN    = 9'b100000000
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  payload;
    logic [NUM_W-1:0]   arg_number;
    logic               last_of_arg;
    logic [NUM_W-1:0]   total_args;
    logic               last_of_run;
  } result_t;

endpackage

@@ rtl/rapc_intf.sv @@
// ----------------------------------------------------------------------------
// rapc channel interfaces
// byte input, result output and register write channels
// ----------------------------------------------------------------------------
interface rapc_in_if;
  import rapc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface rapc_out_if;
  import rapc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] payload;
  logic [NUM_W-1:0]  arg_number;
  logic              last_of_arg;
  logic [NUM_W-1:0]  total_args;
  logic              last_of_run;

  modport source (output valid, output kind, output payload, output arg_number,
                  output last_of_arg, output total_args, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input payload, input arg_number,
                  input last_of_arg, input total_args, input last_of_run,
                  output ready);
endinterface

interface rapc_cfg_if;
  import rapc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NUM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/resp_array_command_parser.sv @@
// ----------------------------------------------------------------------------
// resp_array_command_parser
// byte-wide parser for a resp array of bulk strings
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | accepted when
//  req     | in  | in_byte, end_of_buffer                | valid && ready
//  rsp     | out | kind, payload, arg_number,            | valid && ready
//          |     | last_of_arg, total_args, last_of_run  |
//  cfg     | in  | index, data                           | valid && ready
//
//  one byte is taken per req.ready cycle; state update and results are formed in
//  the same cycle and written into a small result queue (OUT_DEPTH items)
//  a byte may give two results, but a ready output drains the queue at one
//  item per cycle and req.ready drops while more than OUT_DEPTH-2 are queued
//  rst is synchronous and active high and clears all control state
//  cfg.ready is always high; the block does not check it: registers must be written only while the parser is idle
// ----------------------------------------------------------------------------
module resp_array_command_parser #(
  parameter int OUT_DEPTH = rapc_pkg::OUT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  rapc_in_if.sink    req,
  rapc_out_if.source rsp,
  rapc_cfg_if.sink   cfg
);
  import rapc_pkg::*;

  localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int QCNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(OUT_DEPTH - 1);
  localparam logic [QCNT_W-1:0] ROOM_LIM = QCNT_W'(OUT_DEPTH - 2);

  // configuration registers
  logic [NUM_W-1:0] max_arg_count;
  logic [NUM_W-1:0] max_bulk_length;

  // parser state
  phase_t             phase, phase_next;
  logic [ACC_W-1:0]   number_accum, number_accum_next;
  logic               number_negative, number_negative_next;
  logic               digits_seen, digits_seen_next;
  logic               ignore_rest, ignore_rest_next;
  logic [NUM_W-1:0]   arg_total, arg_total_next;
  logic [NUM_W-1:0]   arg_current, arg_current_next;
  logic [NUM_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [TRAIL_W-1:0] trailer_left, trailer_left_next;

  // result queue
  result_t            queue [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [PTR_W-1:0]   wr_ptr_1;

  logic               accept, pop;
  logic [BYTE_W-1:0]  b;
  logic               is_digit;
  logic [3:0]         digit;
  logic [34:0]        num_value, num_limit;
  logic [NUM_W-1:0]   br_dec, ac_inc;
  logic [TRAIL_W-1:0] tl_dec;
  logic               err, finished, main_v, inc_v;
  result_t            main_res, item_a, item_b;
  logic [1:0]         n_res;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign accept    = req.valid && req.ready;
  assign pop       = rsp.valid && rsp.ready;
  assign req.ready = (count <= ROOM_LIM);
  assign cfg.ready = 1'b1;

  assign b         = req.in_byte;
  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign digit     = 4'(b - CHAR_ZERO);
  // accum * 10 + digit, kept wide enough to see overflow
  assign num_value = {number_accum, 3'b000} + {2'b00, number_accum, 1'b0} + {31'd0, digit};
  assign num_limit = number_negative ? 35'h0_8000_0000 : 35'h0_7FFF_FFFF;
  assign br_dec    = bytes_remaining - 1'b1;
  assign tl_dec    = trailer_left - 1'b1;
  assign ac_inc    = arg_current + 1'b1;

  always_comb begin
    phase_next           = phase;
    number_accum_next    = number_accum;
    number_negative_next = number_negative;
    digits_seen_next     = digits_seen;
    ignore_rest_next     = ignore_rest;
    arg_total_next       = arg_total;
    arg_current_next     = arg_current;
    bytes_remaining_next = bytes_remaining;
    trailer_left_next    = trailer_left;
    err                  = 1'b0;
    finished             = 1'b0;
    main_v               = 1'b0;
    main_res             = '0;
    main_res.kind        = KIND_PAYLOAD;

    unique case (phase)
      PH_STAR: begin
        if (b == CHAR_STAR) begin
          number_accum_next    = '0;
          number_negative_next = 1'b0;
          digits_seen_next     = 1'b0;
          ignore_rest_next     = 1'b0;
          phase_next           = PH_COUNT;
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (b == CHAR_CR) begin
          phase_next = (phase == PH_COUNT) ? PH_COUNT_CR : PH_LEN_CR;
        end else if (ignore_rest) begin
          phase_next = phase;
        end else if (is_digit) begin
          if (num_value > num_limit) begin
            err = 1'b1;
          end else begin
            number_accum_next = num_value[ACC_W-1:0];
            digits_seen_next  = 1'b1;
          end
        end else if (b == CHAR_MINUS && !digits_seen && !number_negative) begin
          number_negative_next = 1'b1;
        end else if (digits_seen) begin
          // trailing junk after digits is skipped up to cr
          ignore_rest_next = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_COUNT_CR: begin
        if (b != CHAR_LF || !digits_seen) begin
          err = 1'b1;
        end else if (number_negative || number_accum == '0) begin
          main_v        = 1'b1;
          main_res.kind = KIND_COMPLETE;
          finished      = 1'b1;
        end else if (number_accum > {1'b0, max_arg_count}) begin
          err = 1'b1;
        end else begin
          arg_total_next   = number_accum[NUM_W-1:0];
          arg_current_next = '0;
          phase_next       = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b == CHAR_DOLLAR) begin
          number_accum_next    = '0;
          number_negative_next = 1'b0;
          digits_seen_next     = 1'b0;
          ignore_rest_next     = 1'b0;
          phase_next           = PH_LEN;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_CR: begin
        if (b != CHAR_LF || !digits_seen) begin
          err = 1'b1;
        end else if (number_negative && number_accum != '0) begin
          err = 1'b1;
        end else if (number_accum > {1'b0, max_bulk_length}) begin
          err = 1'b1;
        end else if (number_accum == '0) begin
          main_v              = 1'b1;
          main_res.kind       = KIND_EMPTY;
          main_res.arg_number = arg_current;
          trailer_left_next   = 2'd2;
          phase_next          = PH_TRAILER;
        end else begin
          bytes_remaining_next = number_accum[NUM_W-1:0];
          phase_next           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        bytes_remaining_next = br_dec;
        main_v               = 1'b1;
        main_res.kind        = KIND_PAYLOAD;
        main_res.payload     = b;
        main_res.arg_number  = arg_current;
        main_res.last_of_arg = (br_dec == '0);
        if (br_dec == '0) begin
          trailer_left_next = 2'd2;
          phase_next        = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        // the two bytes after a payload or an empty argument are skipped unchecked
        trailer_left_next = tl_dec;
        if (tl_dec == '0) begin
          arg_current_next = ac_inc;
          if (ac_inc == arg_total) begin
            main_v              = 1'b1;
            main_res.kind       = KIND_COMPLETE;
            main_res.total_args = arg_total;
            finished            = 1'b1;
          end else begin
            phase_next = PH_DOLLAR;
          end
        end
      end
      PH_DRAIN: begin
        finished = 1'b1;
      end
      default: begin
        finished = 1'b1;
      end
    endcase

    if (err) begin
      main_v        = 1'b1;
      main_res      = '0;
      main_res.kind = KIND_ERROR;
      finished      = 1'b1;
    end
    if (finished) begin
      phase_next = PH_DRAIN;
    end

    inc_v = req.end_of_buffer && !finished;
    if (req.end_of_buffer) begin
      phase_next           = PH_STAR;
      number_accum_next    = '0;
      number_negative_next = 1'b0;
      digits_seen_next     = 1'b0;
      ignore_rest_next     = 1'b0;
      arg_total_next       = '0;
      arg_current_next     = '0;
      bytes_remaining_next = '0;
      trailer_left_next    = '0;
    end
  end

  // order results: main or error first, incomplete last
  always_comb begin
    item_b             = '0;
    item_b.kind        = KIND_INCOMPL;
    item_b.last_of_run = 1'b1;
    if (main_v) begin
      item_a             = main_res;
      item_a.last_of_run = !inc_v;
      n_res              = inc_v ? 2'd2 : 2'd1;
    end else begin
      item_a = item_b;
      n_res  = inc_v ? 2'd1 : 2'd0;
    end
  end

  assign wr_ptr_1 = ptr_inc(wr_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_STAR;
      number_accum    <= '0;
      number_negative <= 1'b0;
      digits_seen     <= 1'b0;
      ignore_rest     <= 1'b0;
      arg_total       <= '0;
      arg_current     <= '0;
      bytes_remaining <= '0;
      trailer_left    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      number_accum    <= number_accum_next;
      number_negative <= number_negative_next;
      digits_seen     <= digits_seen_next;
      ignore_rest     <= ignore_rest_next;
      arg_total       <= arg_total_next;
      arg_current     <= arg_current_next;
      bytes_remaining <= bytes_remaining_next;
      trailer_left    <= trailer_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count   <= MAX_DEFAULT;
      max_bulk_length <= MAX_DEFAULT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MAX_ARG_COUNT:   max_arg_count   <= cfg.data;
        REG_MAX_BULK_LENGTH: max_bulk_length <= cfg.data;
        default: begin
          max_arg_count <= max_arg_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        if (n_res == 2'd2) begin
          wr_ptr <= ptr_inc(wr_ptr_1);
        end else if (n_res == 2'd1) begin
          wr_ptr <= wr_ptr_1;
        end
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + (accept ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      queue[wr_ptr] <= item_a;
    end
    if (accept && n_res == 2'd2) begin
      queue[wr_ptr_1] <= item_b;
    end
  end

  assign rsp.valid       = (count != '0);
  assign rsp.kind        = queue[rd_ptr].kind;
  assign rsp.payload     = queue[rd_ptr].payload;
  assign rsp.arg_number  = queue[rd_ptr].arg_number;
  assign rsp.last_of_arg = queue[rd_ptr].last_of_arg;
  assign rsp.total_args  = queue[rd_ptr].total_args;
  assign rsp.last_of_run = queue[rd_ptr].last_of_run;

`include "resp_array_command_parser_defines.svh"

  `RAPC_ASSERT_IMPL(a_queue_bound, 1'b1, count <= QCNT_W'(OUT_DEPTH), "result queue overflow")
  `RAPC_ASSERT_NEXT(a_eob_restart, accept && req.end_of_buffer, phase == PH_STAR, "no restart after end of buffer")
  `RAPC_ASSERT_NEXT(a_drain_silent, accept && phase == PH_DRAIN && !req.end_of_buffer, count == $past(count) - QCNT_W'($past(pop)), "item gave a result while draining")
  `RAPC_ASSERT_IMPL(a_arg_in_range, phase == PH_DOLLAR || phase == PH_LEN || phase == PH_PAYLOAD, arg_current < arg_total, "argument index past count")

endmodule

@@ dv/resp_array_command_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resp_array_command_parser_test
// drives request buffers byte by byte, mostly well-formed commands plus
// broken lines, over-limit values, early ends and noise; a tracker parses
// every accepted byte and each returned item is checked against it
// ----------------------------------------------------------------------------
module resp_array_command_parser_test;
  import rapc_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int PHASE_BYTES = 155;

  // follows the request parse and holds the results still owed by the block
  class command_tracker;
    logic [NUM_W-1:0]   max_args;
    logic [NUM_W-1:0]   max_len;
    phase_t             parse_state;
    logic [ACC_W-1:0]   accum;
    logic               negative;
    logic               digits;
    logic               skip_rest;
    logic [NUM_W-1:0]   arg_total;
    logic [NUM_W-1:0]   arg_index;
    logic [NUM_W-1:0]   bytes_left;
    logic [TRAIL_W-1:0] trailer_left;
    result_t            this_byte[$];
    result_t            pending_results[$];
    int                 fail_count;

    function new();
      max_args = MAX_DEFAULT;
      max_len = MAX_DEFAULT;
      fail_count = 0;
      clear_parse();
    endfunction

    function void clear_number();
      accum = '0;
      negative = 1'b0;
      digits = 1'b0;
      skip_rest = 1'b0;
    endfunction

    function void clear_parse();
      clear_number();
      parse_state = PH_STAR;
      arg_total = '0;
      arg_index = '0;
      bytes_left = '0;
      trailer_left = '0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] value);
      if (idx == REG_MAX_ARG_COUNT) max_args = value;
      else if (idx == REG_MAX_BULK_LENGTH) max_len = value;
    endfunction

    function void add_result(kind_t k, logic [BYTE_W-1:0] b, logic [NUM_W-1:0] argn,
                             logic last, logic [NUM_W-1:0] total);
      result_t r;
      r.kind = k;
      r.payload = b;
      r.arg_number = argn;
      r.last_of_arg = last;
      r.total_args = total;
      r.last_of_run = 1'b0;
      this_byte.push_back(r);
    endfunction

    // one byte of a count or length line; 0 means syntax or range error
    function bit number_char(logic [BYTE_W-1:0] b, phase_t cr_state);
      logic [63:0] v;
      logic [63:0] limit;
      if (b == CHAR_CR) begin
        parse_state = cr_state;
        return 1'b1;
      end
      if (skip_rest) return 1'b1;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        limit = negative ? 64'd2147483648 : 64'd2147483647;
        v = 64'(accum) * 64'd10 + 64'(b - CHAR_ZERO);
        if (v > limit) return 1'b0;
        accum = v[ACC_W-1:0];
        digits = 1'b1;
        return 1'b1;
      end
      if (b == CHAR_MINUS && !digits && !negative) begin
        negative = 1'b1;
        return 1'b1;
      end
      if (digits) begin
        skip_rest = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic eob);
      bit done;
      bit bad;
      done = 1'b0;
      bad = 1'b0;
      this_byte.delete();
      case (parse_state)
        PH_STAR: begin
          if (b == CHAR_STAR) begin
            clear_number();
            parse_state = PH_COUNT;
          end else begin
            bad = 1'b1;
          end
        end
        PH_COUNT: bad = !number_char(b, PH_COUNT_CR);
        PH_LEN: bad = !number_char(b, PH_LEN_CR);
        PH_COUNT_CR: begin
          if (b != CHAR_LF || !digits) begin
            bad = 1'b1;
          end else if (negative || accum == 0) begin
            add_result(KIND_COMPLETE, '0, '0, 1'b0, '0);
            done = 1'b1;
          end else if (accum > {1'b0, max_args}) begin
            bad = 1'b1;
          end else begin
            arg_total = accum[NUM_W-1:0];
            arg_index = '0;
            parse_state = PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (b == CHAR_DOLLAR) begin
            clear_number();
            parse_state = PH_LEN;
          end else begin
            bad = 1'b1;
          end
        end
        PH_LEN_CR: begin
          if (b != CHAR_LF || !digits) begin
            bad = 1'b1;
          end else if (negative && accum != 0) begin
            bad = 1'b1;
          end else if (accum > {1'b0, max_len}) begin
            bad = 1'b1;
          end else if (accum == 0) begin
            add_result(KIND_EMPTY, '0, arg_index, 1'b0, '0);
            trailer_left = 2'd2;
            parse_state = PH_TRAILER;
          end else begin
            bytes_left = accum[NUM_W-1:0];
            parse_state = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          bytes_left = bytes_left - 1'b1;
          add_result(KIND_PAYLOAD, b, arg_index, bytes_left == 0, '0);
          if (bytes_left == 0) begin
            trailer_left = 2'd2;
            parse_state = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          // trailer bytes are skipped without looking at them
          trailer_left = trailer_left - 1'b1;
          if (trailer_left == 0) begin
            arg_index = arg_index + 1'b1;
            if (arg_index == arg_total) begin
              add_result(KIND_COMPLETE, '0, '0, 1'b0, arg_total);
              done = 1'b1;
            end else begin
              parse_state = PH_DOLLAR;
            end
          end
        end
        default: done = 1'b1;
      endcase
      if (bad) begin
        add_result(KIND_ERROR, '0, '0, 1'b0, '0);
        done = 1'b1;
      end
      if (done) parse_state = PH_DRAIN;
      if (eob) begin
        if (!done) add_result(KIND_INCOMPL, '0, '0, 1'b0, '0);
        clear_parse();
      end
      if (this_byte.size() > 0) this_byte[this_byte.size()-1].last_of_run = 1'b1;
      foreach (this_byte[i]) pending_results.push_back(this_byte[i]);
    endfunction

    function bit field_differs(string field, longint unsigned want, longint unsigned seen);
      if (want == seen) return 1'b0;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
      return 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit bad;
      if (pending_results.size() == 0) begin
        $display("%0t: kind expected no item, got %0d", $time, got.kind);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      bad = field_differs("kind", want.kind, got.kind);
      bad |= field_differs("payload", want.payload, got.payload);
      bad |= field_differs("arg_number", want.arg_number, got.arg_number);
      bad |= field_differs("last_of_arg", want.last_of_arg, got.last_of_arg);
      bad |= field_differs("total_args", want.total_args, got.total_args);
      bad |= field_differs("last_of_run", want.last_of_run, got.last_of_run);
      if (bad) fail_count++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rapc_in_if  req_if ();
  rapc_out_if rsp_if ();
  rapc_cfg_if cfg_if ();

  resp_array_command_parser DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  command_tracker   sb;
  logic [BYTE_W-1:0] frame[$];
  bit                send_quiet;
  bit                recv_quiet;
  int                bytes_sent;
  int                stuck_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.in_byte <= b;
    req_if.end_of_buffer <= last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    // a byte with no result may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(logic [NUM_W-1:0] arg_cap, logic [NUM_W-1:0] len_cap);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_MAX_ARG_COUNT;
    cfg_if.data <= arg_cap;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_limit(REG_MAX_ARG_COUNT, arg_cap);
    cfg_if.index <= REG_MAX_BULK_LENGTH;
    cfg_if.data <= len_cap;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_limit(REG_MAX_BULK_LENGTH, len_cap);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic put_crlf();
    frame.push_back(CHAR_CR);
    frame.push_back(CHAR_LF);
  endtask

  // number line with an occasional defect: junk first, extra minus, leading
  // zero, no digits, ignored tail, or a cr without lf
  task automatic put_number(longint value);
    string s;
    int mode;
    logic [BYTE_W-1:0] b;
    s = $sformatf("%0d", value);
    mode = $urandom_range(0, 24);
    if (mode == 0) frame.push_back(8'($urandom_range(97, 122)));
    if (mode == 1) frame.push_back(CHAR_MINUS);
    if (mode == 2) frame.push_back(CHAR_ZERO);
    if (mode != 3) put_text(s);
    if (mode == 4) begin
      frame.push_back(8'h20);
      frame.push_back(8'($urandom_range(97, 122)));
    end
    if (mode == 5) begin
      frame.push_back(CHAR_CR);
      b = 8'($urandom_range(0, 255));
      frame.push_back(b == CHAR_LF ? 8'h78 : b);
    end else begin
      put_crlf();
    end
  endtask

  task automatic build_command();
    longint count;
    longint len;
    int args;
    int n;
    frame.delete();
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 1) == 0) frame.push_back(CHAR_STAR);
      repeat (n) frame.push_back(8'($urandom_range(0, 255)));
      return;
    end
    frame.push_back($urandom_range(0, 39) == 0 ? 8'($urandom_range(0, 255)) : CHAR_STAR);
    case ($urandom_range(0, 19))
      0: count = 0;
      1: count = -longint'($urandom_range(1, 5));
      2: count = -64'sd2147483648;
      3: count = -64'sd2147483649;
      4: count = 64'sd2147483647;
      5: count = 64'sd2147483648;
      6: count = longint'(sb.max_args) + 1;
      7: count = 64'sd98765432109;
      default: count = $urandom_range(1, 4);
    endcase
    put_number(count);
    args = (count >= 1 && count <= 4) ? int'(count) : $urandom_range(0, 2);
    repeat (args) begin
      frame.push_back($urandom_range(0, 39) == 0 ? CHAR_STAR : CHAR_DOLLAR);
      case ($urandom_range(0, 19))
        0: len = -1;
        1: len = longint'(sb.max_len) + 1;
        2: len = 64'sd2147483647;
        3, 4: len = $urandom_range(7, 40);
        5: len = 0;
        default: len = $urandom_range(0, 6);
      endcase
      put_number(len);
      n = (len >= 0 && len <= 40) ? int'(len) : $urandom_range(0, 4);
      repeat (n) frame.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(8'($urandom_range(0, 255)));
      end else begin
        put_crlf();
      end
    end
    // buffer cut short, or trailing bytes after the command
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, frame.size());
      while (frame.size() > n) void'(frame.pop_back());
    end
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3))
      frame.push_back(8'($urandom_range(0, 255)));
  endtask

  // result side
  initial begin
    int stall;
    result_t got;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
      got.kind = kind_t'(rsp_if.kind);
      got.payload = rsp_if.payload;
      got.arg_number = rsp_if.arg_number;
      got.last_of_arg = rsp_if.last_of_arg;
      got.total_args = rsp_if.total_args;
      got.last_of_run = rsp_if.last_of_run;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("resp_array_command_parser_test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int target;
    sb = new();
    bytes_sent = 0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    req_if.valid <= 1'b0;
    req_if.in_byte <= '0;
    req_if.end_of_buffer <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_MAX_ARG_COUNT;
    cfg_if.data <= '0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero count, empty argument, bad lead byte, buffer ending in a payload
    frame.delete();
    put_text("*0");
    put_crlf();
    send_frame();
    frame.delete();
    put_text("*1");
    put_crlf();
    put_text("$0");
    put_crlf();
    put_crlf();
    send_frame();
    frame.delete();
    frame.push_back(8'h00);
    send_frame();
    frame.delete();
    put_text("*1");
    put_crlf();
    put_text("$2");
    put_crlf();
    frame.push_back(8'hFF);
    send_frame();
    wait_drained();

    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      case (phase_no)
        0: write_limits(MAX_DEFAULT, MAX_DEFAULT);
        1: write_limits(31'd2, 31'd3);
        2: write_limits(31'd0, 31'd0);
        3: write_limits(31'($urandom_range(1, 5)), 31'($urandom_range(1, 8)));
        4: write_limits(31'd1, MAX_DEFAULT);
        default: write_limits(MAX_DEFAULT, 31'd5);
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_command();
        send_quiet = $urandom_range(0, 4) == 0;
        recv_quiet = $urandom_range(0, 4) == 0;
        send_frame();
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("resp_array_command_parser_test passed");
    end else begin
      $display("resp_array_command_parser_test failed");
    end
    $finish;
  end

endmodule
